@@ src/utf16_to_utf8_transcoder_defines.svh @@
// Assertion macros shared by the UTF-16 to UTF-8 transcoder.
// Standalone header; it is included by the top level.
`ifndef UTF16_TO_UTF8_TRANSCODER_DEFINES_SVH
`define UTF16_TO_UTF8_TRANSCODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UTT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("transcoder check failed");

// The consequent must hold in the cycle after the antecedent.
`define UTT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("transcoder check failed");

`endif

@@ src/utt_pkg.sv @@
// Types and constants of the UTF-16 to UTF-8 transcoder.
// No dependencies; the front end, the queue, the back end and the top level import it.
package utt_pkg;

   localparam int UTT_QUEUE_DEPTH = 4;
   localparam int UTT_MAX_BYTES   = 6;
   localparam int UTT_IDX_W       = 3;

   localparam logic [15:0] UTT_ASCII_MASK = 16'hFF80;
   localparam logic [15:0] UTT_TWO_MASK   = 16'hF800;
   localparam logic [15:0] UTT_SURR_MASK  = 16'hFC00;
   localparam logic [15:0] UTT_HIGH_SURR  = 16'hD800;
   localparam logic [15:0] UTT_LOW_SURR   = 16'hDC00;
   localparam logic [20:0] UTT_PLANE_BASE = 21'h10000;

   localparam logic [7:0] UTT_LEAD4 = 8'hF0;
   localparam logic [7:0] UTT_LEAD3 = 8'hE0;
   localparam logic [7:0] UTT_LEAD2 = 8'hC0;
   localparam logic [7:0] UTT_CONT  = 8'h80;

   typedef logic [7:0] byte_type;

   typedef struct packed {
      byte_type [UTT_MAX_BYTES-1:0] bytes;
      logic [UTT_IDX_W-1:0]         last_idx;
      logic                         text_end;
   } job_type;

   typedef struct packed {
      logic valid;
      logic full;
   } queue_status_type;

endpackage

@@ src/utt_req_if.sv @@
// Input channel of the transcoder: one UTF-16 code unit per item.
// No dependencies.
interface utt_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;

   modport source (output valid, output code_unit, input ready);
   modport sink (input valid, input code_unit, output ready);
endinterface

@@ src/utt_rsp_if.sv @@
// Result channel of the transcoder: one UTF-8 byte per item.
// No dependencies.
interface utt_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       text_end;

   modport source (output valid, output out_byte, output run_last, output text_end,
                   input ready);
   modport sink (input valid, input out_byte, input run_last, input text_end,
                 output ready);
endinterface

@@ src/utt_front.sv @@
// Front end: accepts code units, tracks a held high surrogate and builds byte jobs.
// Depends on utt_pkg and utt_req_if.
module utt_front (
   input  logic                      clock,
   input  logic                      reset,
   utt_req_if.sink                   req_chan,
   input  utt_pkg::queue_status_type q_stat,
   output utt_pkg::job_type          job,
   output logic                      push
);
   import utt_pkg::*;

   logic       held_valid_ff, held_valid_in;
   logic [9:0] held_high_ff, held_high_in;

   logic [15:0]    unit;
   logic           accept, is_low, is_high, pair;
   logic [20:0]    cp;
   logic [15:0]    flush_unit;
   byte_type [2:0] nb;
   logic [1:0]     nn;
   logic           new_end;
   logic [2:0]     count;

   assign unit           = req_chan.code_unit;
   assign req_chan.ready = !q_stat.full;
   assign accept         = req_chan.valid && !q_stat.full;

   assign is_low     = (unit & UTT_SURR_MASK) == UTT_LOW_SURR;
   assign is_high    = (unit & UTT_SURR_MASK) == UTT_HIGH_SURR;
   assign pair       = held_valid_ff && is_low;
   assign cp         = UTT_PLANE_BASE + {1'b0, held_high_ff, unit[9:0]};
   assign flush_unit = UTT_HIGH_SURR | {6'b0, held_high_ff};

   always_comb begin
      nb      = '0;
      nn      = 2'd0;
      new_end = 1'b0;
      if (unit == 16'h0000) begin
         nn      = 2'd1;
         new_end = 1'b1;
      end else if ((unit & UTT_ASCII_MASK) == 16'h0000) begin
         nb[0] = unit[7:0];
         nn    = 2'd1;
      end else if ((unit & UTT_TWO_MASK) == 16'h0000) begin
         nb[0] = UTT_LEAD2 | {3'b0, unit[10:6]};
         nb[1] = UTT_CONT | {2'b0, unit[5:0]};
         nn    = 2'd2;
      end else if (!is_high) begin
         nb[0] = UTT_LEAD3 | {4'b0, unit[15:12]};
         nb[1] = UTT_CONT | {2'b0, unit[11:6]};
         nb[2] = UTT_CONT | {2'b0, unit[5:0]};
         nn    = 2'd3;
      end
   end

   always_comb begin
      job.bytes    = '0;
      job.text_end = 1'b0;
      count        = 3'd0;
      if (pair) begin
         job.bytes[0] = UTT_LEAD4 | {5'b0, cp[20:18]};
         job.bytes[1] = UTT_CONT | {2'b0, cp[17:12]};
         job.bytes[2] = UTT_CONT | {2'b0, cp[11:6]};
         job.bytes[3] = UTT_CONT | {2'b0, cp[5:0]};
         count        = 3'd4;
      end else if (held_valid_ff) begin
         job.bytes[0] = UTT_LEAD3 | {4'b0, flush_unit[15:12]};
         job.bytes[1] = UTT_CONT | {2'b0, flush_unit[11:6]};
         job.bytes[2] = UTT_CONT | {2'b0, flush_unit[5:0]};
         job.bytes[3] = nb[0];
         job.bytes[4] = nb[1];
         job.bytes[5] = nb[2];
         job.text_end = new_end;
         count        = 3'd3 + {1'b0, nn};
      end else begin
         job.bytes[0] = nb[0];
         job.bytes[1] = nb[1];
         job.bytes[2] = nb[2];
         job.text_end = new_end;
         count        = {1'b0, nn};
      end
      job.last_idx = count - 3'd1;
   end

   assign push = accept && (count != 3'd0);

   always_comb begin
      held_valid_in = held_valid_ff;
      held_high_in  = held_high_ff;
      if (accept) begin
         held_valid_in = !pair && is_high;
         held_high_in  = (!pair && is_high) ? unit[9:0] : 10'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         held_high_ff  <= 10'd0;
      end else begin
         held_valid_ff <= held_valid_in;
         held_high_ff  <= held_high_in;
      end
   end

endmodule

@@ src/utt_queue.sv @@
// Job queue between the front end and the byte serializer.
// Depends on utt_pkg.
module utt_queue #(
   parameter int DEPTH = utt_pkg::UTT_QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  utt_pkg::job_type          job_in,
   input  logic                      pop,
   output utt_pkg::job_type          head,
   output utt_pkg::queue_status_type q_stat
);
   import utt_pkg::*;

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   job_type             mem_ff [DEPTH];
   logic [ADDR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [ADDR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push, do_pop;

   assign q_stat.valid = count_ff != '0;
   assign q_stat.full  = count_ff == CNT_W'(DEPTH);
   assign head         = mem_ff[rd_ptr_ff];

   assign do_push = push && !q_stat.full;
   assign do_pop  = pop && q_stat.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= job_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ src/utt_back.sv @@
// Back end: sends the bytes of the queue head one per item through an output register.
// Depends on utt_pkg and utt_rsp_if.
module utt_back (
   input  logic                      clock,
   input  logic                      reset,
   input  utt_pkg::job_type          head,
   input  utt_pkg::queue_status_type q_stat,
   output logic                      pop,
   utt_rsp_if.source                 rsp_chan
);
   import utt_pkg::*;

   logic [UTT_IDX_W-1:0] idx_ff, idx_in;
   logic                 valid_ff, valid_in;
   byte_type             byte_ff, byte_in;
   logic                 last_ff, last_in;
   logic                 end_ff, end_in;
   logic                 out_free, fire, at_last;

   assign out_free = !valid_ff || rsp_chan.ready;
   assign fire     = q_stat.valid && out_free;
   assign at_last  = idx_ff == head.last_idx;
   assign pop      = fire && at_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff && !rsp_chan.ready;
      byte_in  = byte_ff;
      last_in  = last_ff;
      end_in   = end_ff;
      if (fire) begin
         valid_in = 1'b1;
         byte_in  = head.bytes[idx_ff];
         last_in  = at_last;
         end_in   = at_last && head.text_end;
         idx_in   = at_last ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
      last_ff <= last_in;
      end_ff  <= end_in;
   end

   assign rsp_chan.valid    = valid_ff;
   assign rsp_chan.out_byte = byte_ff;
   assign rsp_chan.run_last = last_ff;
   assign rsp_chan.text_end = end_ff;

endmodule

@@ src/utf16_to_utf8_transcoder.sv @@
// The first byte of a unit passes through the job queue and then the output register.
// Throughput: one byte per cycle while the output is not stalled, set by the output register;
// a unit yields one to six bytes, and a high surrogate alone yields none until the next unit.
// Units are accepted each cycle while the job queue has room.
// Reset clears the held surrogate, the job queue and the valid flag of the output register.
// Depends on utt_pkg, utt_req_if, utt_rsp_if, utt_front, utt_queue and utt_back.
`include "utf16_to_utf8_transcoder_defines.svh"

module utf16_to_utf8_transcoder #(
   parameter int QUEUE_DEPTH = utt_pkg::UTT_QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   utt_req_if.sink   req_chan,
   utt_rsp_if.source rsp_chan
);
   import utt_pkg::*;

   job_type          job, head;
   logic             push, pop;
   queue_status_type q_stat;

   utt_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_stat   (q_stat),
      .job      (job),
      .push     (push)
   );

   utt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .job_in (job),
      .pop    (pop),
      .head   (head),
      .q_stat (q_stat)
   );

   utt_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_stat   (q_stat),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

   `UTT_ASSERT_SAME(a_end_is_last, clock, reset, rsp_chan.valid && rsp_chan.text_end, rsp_chan.run_last && rsp_chan.out_byte == 8'h00)
   `UTT_ASSERT_NEXT(a_run_continues, clock, reset, rsp_chan.valid && rsp_chan.ready && !rsp_chan.run_last, rsp_chan.valid)
   `UTT_ASSERT_SAME(a_full_has_head, clock, reset, q_stat.full, q_stat.valid && !req_chan.ready)

endmodule
